// ----- rtl/core/qeh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qeh_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [3:0] LIMIT_RESET = 4'd3;

    localparam logic [15:0] HEADING_LIM = 16'd23040;
    localparam logic [15:0] ROLL_LIM = 16'd11520;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [2:0] STATUS_OK = 3'd0;
    localparam logic [2:0] STATUS_NOT_INIT = 3'd1;
    localparam logic [2:0] STATUS_TIMEOUT = 3'd2;
    localparam logic [2:0] STATUS_INVALID = 3'd3;
    localparam logic [2:0] STATUS_FAIL_REC = 3'd4;
    localparam logic [2:0] STATUS_INIT_ACK = 3'd5;

    // atan(2^-i) in degrees scaled by 2^16.
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qeh_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qeh_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [56:0] radicand,
    output logic             done,
    output logic [28:0]      root
);

    logic        busy_reg;
    logic [4:0]  j_reg;
    logic [56:0] v_reg;
    logic [56:0] r_reg;
    logic [56:0] bit_val;
    logic [57:0] rb;
    logic        take;
    logic [56:0] r_new;
    logic [56:0] v_new;

    always_comb begin
        bit_val = 57'd1 << (6'd56 - {j_reg, 1'b0});
        rb = {1'b0, r_reg} + {1'b0, bit_val};
        take = ({1'b0, v_reg} >= rb);
        if (take) begin
            v_new = v_reg - rb[56:0];
            r_new = (r_reg >> 1) + bit_val;
        end else begin
            v_new = v_reg;
            r_new = r_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            j_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                j_reg <= '0;
                v_reg <= radicand;
                r_reg <= '0;
            end else if (busy_reg) begin
                v_reg <= v_new;
                r_reg <= r_new;
                j_reg <= j_reg + 5'd1;
                if (j_reg == 5'd28) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                    root <= r_new[28:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/qeh_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qeh_cordic #(
    parameter int CORDIC_STEPS = qeh_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [39:0] x_in,
    input  wire logic signed [39:0] y_in,
    input  wire logic [15:0]        lim,
    output logic                    done,
    output logic signed [15:0]      angle
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic signed [26:0] HALF_TURN = 27'sd11796480;

    logic                    busy_reg;
    logic                    fin_reg;
    logic [IW-1:0]           i_reg;
    logic signed [39:0]      x_reg;
    logic signed [39:0]      y_reg;
    logic signed [26:0]      ang_reg;
    logic signed [39:0]      xs;
    logic signed [39:0]      ys;
    logic signed [26:0]      step_ang;
    logic signed [26:0]      rnd;
    logic signed [26:0]      lim_s;
    logic [15:0]             lim_reg;

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        step_ang = signed'({5'd0, qeh_pkg::atan_q16(5'(i_reg))});
        rnd = (ang_reg + 27'sd256) >>> 9;
        lim_s = signed'({11'd0, lim_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done <= 1'b0;
            i_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                lim_reg <= lim;
                i_reg <= '0;
                if (x_in == 40'sd0 && y_in == 40'sd0) begin
                    ang_reg <= '0;
                    fin_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    if (x_in < 40'sd0) begin
                        x_reg <= -x_in;
                        y_reg <= -y_in;
                        ang_reg <= (y_in >= 40'sd0) ? HALF_TURN : -HALF_TURN;
                    end else begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        ang_reg <= '0;
                    end
                end
            end else if (busy_reg) begin
                if (y_reg >= 40'sd0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    ang_reg <= ang_reg + step_ang;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    ang_reg <= ang_reg - step_ang;
                end
                i_reg <= i_reg + IW'(1);
                if (i_reg == IW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg <= 1'b0;
                done <= 1'b1;
                if (rnd > lim_s) begin
                    angle <= lim_s[15:0];
                end else if (rnd < -lim_s) begin
                    angle <= -lim_s[15:0];
                end else begin
                    angle <= rnd[15:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/quaternion_euler_with_health_watch_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Turns IMU samples into heading, roll and pitch and watches sensor health.
// The input stream (s_axis_*) carries one word per sample or initialisation
// report; tuser selects which. The output stream (m_axis_*) returns exactly
// one word per input word, with a status code in tuser and the held angles,
// last good acceleration and ready flag in tdata. The cfg_* channel writes the
// timeout and failure limit and is always ready.
// A word that does not need the angle path goes from ST_DECIDE straight to
// ST_FIN, where its result is loaded into the output register. A good sample
// passes through ten products on one shared multiplier, one squaring, a
// 29-step square root and three 16-step CORDIC runs on one shared CORDIC
// engine. One word is worked on at a time and s_axis_tready is low until the
// result has been loaded into the output register. If the receiver stalls, the
// result waits in ST_FIN and no new word is taken until the register frees.
// Reset clears the ready flag, the watchdog and all held values, and sets the
// timeout to 3000 ms and the failure limit to 3.
module quaternion_euler_with_health_watch_core #(
    parameter int CORDIC_STEPS = qeh_pkg::CORDIC_STEPS_DEF,
    parameter int TIME_BITS = qeh_pkg::TIME_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // now_ms, init_ok, quat_w, quat_x, quat_y, quat_z, acc_x, acc_y, acc_z, zero fill
    input  wire logic [151:0] s_axis_tdata,
    // req_type
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // heading_out, roll_out, pitch_out, acc_x_out, acc_y_out, acc_z_out, ready_flag
    output logic [95:0]       m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_MUL = 4'd2;
    localparam logic [3:0] ST_SQ = 4'd3;
    localparam logic [3:0] ST_SQRT_GO = 4'd4;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd5;
    localparam logic [3:0] ST_COR_GO = 4'd6;
    localparam logic [3:0] ST_COR_WAIT = 4'd7;
    localparam logic [3:0] ST_FIN = 4'd8;

    logic [3:0]               state_reg;
    logic [3:0]               cnt_reg;
    logic [1:0]               run_reg;

    logic                     req_reg;
    logic [31:0]              now_reg;
    logic                     init_reg;
    logic signed [15:0]       qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [15:0]       ax_reg, ay_reg, az_reg;

    logic [15:0]              timeout_reg;
    logic [3:0]               limit_reg;
    logic                     is_ready_reg;
    logic [TIME_BITS-1:0]     lgt_reg;
    logic [3:0]               fc_reg;
    logic signed [15:0]       heading_reg;
    logic signed [14:0]       roll_reg;
    logic signed [15:0]       pitch_reg;
    logic signed [15:0]       accx_reg, accy_reg, accz_reg;
    logic [2:0]               status_reg;

    logic signed [33:0]       sd_reg, hy_reg, hx_reg, py_reg, px_reg;
    logic signed [59:0]       prod_reg;
    logic signed [29:0]       s_reg;
    logic [28:0]              c_reg;

    logic signed [29:0]       ma, mb;
    logic signed [33:0]       p34;
    logic signed [34:0]       two_sd;
    logic signed [29:0]       s_c;
    logic [28:0]              sa;
    logic [63:0]              now64;
    logic [TIME_BITS-1:0]     now_tb;
    logic [TIME_BITS-1:0]     elapsed;
    logic [3:0]               fc_inc;
    logic                     acc_zero;
    logic                     out_load;

    logic                     sq_start, sq_done;
    logic [56:0]              radicand;
    logic [28:0]              root;
    logic                     cor_start, cor_done;
    logic signed [39:0]       cor_x, cor_y;
    logic [15:0]              cor_lim;
    logic signed [15:0]       cor_angle;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load = (state_reg == ST_FIN) && (!m_axis_tvalid || m_axis_tready);

    always_comb begin
        unique case (cnt_reg)
            4'd0: begin ma = 30'(qw_reg); mb = 30'(qy_reg); end
            4'd1: begin ma = 30'(qz_reg); mb = 30'(qx_reg); end
            4'd2: begin ma = 30'(qw_reg); mb = 30'(qz_reg); end
            4'd3: begin ma = 30'(qx_reg); mb = 30'(qy_reg); end
            4'd4: begin ma = 30'(qy_reg); mb = 30'(qy_reg); end
            4'd5: begin ma = 30'(qz_reg); mb = 30'(qz_reg); end
            4'd6: begin ma = 30'(qw_reg); mb = 30'(qx_reg); end
            4'd7: begin ma = 30'(qy_reg); mb = 30'(qz_reg); end
            4'd8: begin ma = 30'(qx_reg); mb = 30'(qx_reg); end
            4'd9: begin ma = 30'(qy_reg); mb = 30'(qy_reg); end
            default: begin ma = signed'({1'b0, sa}); mb = signed'({1'b0, sa}); end
        endcase
        p34 = prod_reg[33:0];
        two_sd = {sd_reg, 1'b0};
        if (two_sd > 35'sd268435456) begin
            s_c = 30'sd268435456;
        end else if (two_sd < -35'sd268435456) begin
            s_c = -30'sd268435456;
        end else begin
            s_c = two_sd[29:0];
        end
        sa = (s_c < 30'sd0) ? 29'(-s_c) : 29'(s_c);
        radicand = (57'd1 << 56) - prod_reg[56:0];
        now64 = {32'd0, now_reg};
        now_tb = now64[TIME_BITS-1:0];
        elapsed = now_tb - lgt_reg;
        fc_inc = (fc_reg == 4'd15) ? fc_reg : fc_reg + 4'd1;
        acc_zero = (ax_reg == 16'sd0) && (ay_reg == 16'sd0) && (az_reg == 16'sd0);
        unique case (run_reg)
            2'd0: begin
                cor_y = {{5{hy_reg[33]}}, hy_reg, 1'b0};
                cor_x = 40'sd268435456 - {{5{hx_reg[33]}}, hx_reg, 1'b0};
                cor_lim = qeh_pkg::HEADING_LIM;
            end
            2'd1: begin
                cor_y = {{10{s_reg[29]}}, s_reg};
                cor_x = signed'({11'd0, c_reg});
                cor_lim = qeh_pkg::ROLL_LIM;
            end
            default: begin
                cor_y = {{5{py_reg[33]}}, py_reg, 1'b0};
                cor_x = 40'sd268435456 - {{5{px_reg[33]}}, px_reg, 1'b0};
                cor_lim = qeh_pkg::HEADING_LIM;
            end
        endcase
    end

    assign sq_start = (state_reg == ST_SQRT_GO);
    assign cor_start = (state_reg == ST_COR_GO);

    qeh_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    qeh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .x_in    (cor_x),
        .y_in    (cor_y),
        .lim     (cor_lim),
        .done    (cor_done),
        .angle   (cor_angle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            run_reg <= '0;
            timeout_reg <= qeh_pkg::TIMEOUT_RESET;
            limit_reg <= qeh_pkg::LIMIT_RESET;
            is_ready_reg <= 1'b0;
            lgt_reg <= '0;
            fc_reg <= '0;
            heading_reg <= '0;
            roll_reg <= '0;
            pitch_reg <= '0;
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    qeh_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                    qeh_pkg::CFG_LIMIT: limit_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        req_reg <= s_axis_tuser;
                        now_reg <= s_axis_tdata[31:0];
                        init_reg <= s_axis_tdata[32];
                        qw_reg <= s_axis_tdata[48:33];
                        qx_reg <= s_axis_tdata[64:49];
                        qy_reg <= s_axis_tdata[80:65];
                        qz_reg <= s_axis_tdata[96:81];
                        ax_reg <= s_axis_tdata[112:97];
                        ay_reg <= s_axis_tdata[128:113];
                        az_reg <= s_axis_tdata[144:129];
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    priority if (req_reg) begin
                        status_reg <= qeh_pkg::STATUS_INIT_ACK;
                        is_ready_reg <= init_reg;
                        if (init_reg) begin
                            lgt_reg <= now_tb;
                            fc_reg <= '0;
                        end
                        state_reg <= ST_FIN;
                    end else if (!is_ready_reg) begin
                        status_reg <= qeh_pkg::STATUS_NOT_INIT;
                        state_reg <= ST_FIN;
                    end else if (lgt_reg != '0 && elapsed > TIME_BITS'(timeout_reg)) begin
                        is_ready_reg <= 1'b0;
                        fc_reg <= '0;
                        status_reg <= qeh_pkg::STATUS_TIMEOUT;
                        state_reg <= ST_FIN;
                    end else if (acc_zero) begin
                        if (fc_inc >= limit_reg) begin
                            is_ready_reg <= 1'b0;
                            fc_reg <= '0;
                            status_reg <= qeh_pkg::STATUS_FAIL_REC;
                        end else begin
                            fc_reg <= fc_inc;
                            status_reg <= qeh_pkg::STATUS_INVALID;
                        end
                        state_reg <= ST_FIN;
                    end else begin
                        accx_reg <= ax_reg;
                        accy_reg <= ay_reg;
                        accz_reg <= az_reg;
                        lgt_reg <= now_tb;
                        fc_reg <= '0;
                        status_reg <= qeh_pkg::STATUS_OK;
                        cnt_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg != 4'd10) begin
                        prod_reg <= ma * mb;
                    end
                    unique case (cnt_reg)
                        4'd1: sd_reg <= p34;
                        4'd2: sd_reg <= sd_reg - p34;
                        4'd3: hy_reg <= p34;
                        4'd4: hy_reg <= hy_reg + p34;
                        4'd5: hx_reg <= p34;
                        4'd6: hx_reg <= hx_reg + p34;
                        4'd7: py_reg <= p34;
                        4'd8: py_reg <= py_reg + p34;
                        4'd9: px_reg <= p34;
                        4'd10: px_reg <= px_reg + p34;
                        default: ;
                    endcase
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd10) begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    prod_reg <= ma * mb;
                    s_reg <= s_c;
                    state_reg <= ST_SQRT_GO;
                end
                ST_SQRT_GO: begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sq_done) begin
                        c_reg <= root;
                        run_reg <= '0;
                        state_reg <= ST_COR_GO;
                    end
                end
                ST_COR_GO: begin
                    state_reg <= ST_COR_WAIT;
                end
                ST_COR_WAIT: begin
                    if (cor_done) begin
                        unique case (run_reg)
                            2'd0: heading_reg <= cor_angle;
                            2'd1: roll_reg <= cor_angle[14:0];
                            default: pitch_reg <= cor_angle;
                        endcase
                        run_reg <= run_reg + 2'd1;
                        state_reg <= (run_reg == 2'd2) ? ST_FIN : ST_COR_GO;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_axis_tuser <= status_reg;
                        m_axis_tdata <= {is_ready_reg, accz_reg, accy_reg, accx_reg,
                                         pitch_reg, roll_reg, heading_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser <= qeh_pkg::STATUS_INIT_ACK))
        else $error("status code out of range");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd11520 &&
                           $signed(m_axis_tdata[30:16]) >= -15'sd11520))
        else $error("roll out of range");

    a_ok_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == qeh_pkg::STATUS_OK) |-> m_axis_tdata[95])
        else $error("good sample reported while not ready");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_DECIDE))
        else $error("accepted word not taken into the sequencer");
`endif

endmodule
`default_nettype wire
